// ===== hw/rtl/tce_pkg.sv =====
package tce_pkg;

    localparam int unsigned WORD_W      = 16;
    localparam int unsigned NUM_GP      = 8;
    localparam int unsigned GP_IDX_W    = $clog2(NUM_GP);

    localparam int unsigned STACK_DEPTH = 256;
    localparam int unsigned STK_IDX_W   = $clog2(STACK_DEPTH);

    localparam int unsigned Q_DEPTH     = 2;
    localparam int unsigned Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W     = $clog2(Q_DEPTH + 1);

    localparam logic [WORD_W-1:0] RESET_SP   = 16'h8200;
    localparam logic [WORD_W-1:0] STACK_FILL = 16'hAAAA;
    localparam logic [WORD_W-1:0] HALT_WORD  = 16'hFFFF;
    localparam logic [WORD_W-1:0] PC_STEP    = 16'h0002;
    localparam logic [WORD_W-1:0] SP_STEP    = 16'h0002;

    // Major opcodes, bits 15..12 of the instruction word.
    localparam logic [3:0] OPC_SYS = 4'd0;
    localparam logic [3:0] OPC_MOV = 4'd1;
    localparam logic [3:0] OPC_ADD = 4'd4;
    localparam logic [3:0] OPC_SUB = 4'd5;
    localparam logic [3:0] OPC_MUL = 4'd6;
    localparam logic [3:0] OPC_AND = 4'd7;
    localparam logic [3:0] OPC_OR  = 4'd8;
    localparam logic [3:0] OPC_XOR = 4'd9;

    // Sub codes of opcode 0, type 0.
    localparam logic [1:0] SSUB_CMP     = 2'd0;
    localparam logic [1:0] SSUB_PUSH    = 2'd1;
    localparam logic [1:0] SSUB_POP     = 2'd2;
    localparam logic [1:0] SSUB_CMP_ALT = 2'd3;

    // Sub codes of opcode 0, type 1.
    localparam logic [1:0] JSUB_ALWAYS = 2'd0;
    localparam logic [1:0] JSUB_EQ     = 2'd1;
    localparam logic [1:0] JSUB_LT     = 2'd2;
    localparam logic [1:0] JSUB_GT     = 2'd3;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_MOV_R,
        OP_MOV_I,
        OP_PUSH,
        OP_POP,
        OP_CMP,
        OP_JMP,
        OP_JEQ,
        OP_JLT,
        OP_JGT,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_AND,
        OP_OR,
        OP_XOR
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [GP_IDX_W-1:0] rd;
        logic [GP_IDX_W-1:0] rm;
        logic [GP_IDX_W-1:0] rn;
        logic [7:0]          imm;
        logic [WORD_W-1:0]   off;
        logic                halt;
    } t_dec;

    typedef struct packed {
        logic [WORD_W-1:0]   next_pc;
        logic                wr;
        logic [GP_IDX_W-1:0] idx;
        logic [WORD_W-1:0]   value;
        logic                pop;
        logic                zf;
        logic                lf;
        logic [WORD_W-1:0]   sp;
        logic                halt;
    } t_res;

endpackage

// ===== hw/rtl/tce_front.sv =====
module tce_front import tce_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [WORD_W-1:0] i_instr,
    output logic              o_full,
    output t_dec              o_dec,
    output logic              o_dec_valid,
    input  logic              i_dec_take
);

    t_dec               r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp;
    logic [Q_PTR_W-1:0] r_rp;
    logic [Q_CNT_W-1:0] r_cnt;
    t_dec               dec;
    logic               push_ok;
    logic               take_ok;
    logic [3:0]         opc;
    logic [1:0]         sub;

    always_comb begin
        opc      = i_instr[15:12];
        sub      = i_instr[1:0];
        dec.op   = OP_NOP;
        dec.rd   = i_instr[10:8];
        dec.rm   = i_instr[7:5];
        dec.rn   = i_instr[4:2];
        dec.imm  = i_instr[7:0];
        dec.off  = {{(WORD_W - 9){i_instr[10]}}, i_instr[10:2]};
        dec.halt = (i_instr == HALT_WORD);
        unique case (opc)
            OPC_SYS: begin
                if (i_instr[11]) begin
                    unique case (sub)
                        JSUB_ALWAYS: dec.op = OP_JMP;
                        JSUB_EQ:     dec.op = OP_JEQ;
                        JSUB_LT:     dec.op = OP_JLT;
                        JSUB_GT:     dec.op = OP_JGT;
                    endcase
                end else begin
                    unique case (sub) inside
                        SSUB_PUSH:              dec.op = OP_PUSH;
                        SSUB_POP:               dec.op = OP_POP;
                        SSUB_CMP, SSUB_CMP_ALT: dec.op = OP_CMP;
                    endcase
                end
            end
            OPC_MOV: dec.op = i_instr[11] ? OP_MOV_I : OP_MOV_R;
            OPC_ADD: dec.op = OP_ADD;
            OPC_SUB: dec.op = OP_SUB;
            OPC_MUL: dec.op = OP_MUL;
            OPC_AND: dec.op = OP_AND;
            OPC_OR:  dec.op = OP_OR;
            OPC_XOR: dec.op = OP_XOR;
            default: dec.op = OP_NOP;
        endcase
    end

    assign o_full      = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_dec_valid = (r_cnt != '0);
    assign o_dec       = r_q[r_rp];
    assign push_ok     = i_push && !o_full;
    assign take_ok     = i_dec_take && o_dec_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wp <= (r_wp == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (take_ok) begin
                r_rp <= (r_rp == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (push_ok && !take_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (take_ok && !push_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wp] <= dec;
        end
    end

endmodule

// ===== hw/rtl/tce_back.sv =====
module tce_back import tce_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_dec i_dec,
    input  logic i_dec_valid,
    output logic o_dec_take,
    output t_res o_res,
    output logic o_res_valid,
    input  logic i_pop
);

    // Execute stage
    t_dec              r_x;
    logic              r_x_vld;
    logic [WORD_W-1:0] r_ra;
    logic [WORD_W-1:0] r_rb;

    // Result stage
    t_res              r_w;
    logic              r_w_vld;

    // Architectural state
    logic [WORD_W-1:0] r_rf [NUM_GP];
    logic [NUM_GP-1:0] r_rf_vld;
    logic [WORD_W-1:0] r_pc;
    logic [WORD_W-1:0] r_sp;
    logic              r_zf;
    logic              r_lf;

    // Stack memory
    logic [WORD_W-1:0]      r_stk [STACK_DEPTH];
    logic [STACK_DEPTH-1:0] r_stk_vld;
    logic [WORD_W-1:0]      r_stk_rd;
    logic                   r_stk_rd_vld;

    logic [WORD_W-1:0]    w_val;
    logic                 w_fwd;
    logic                 w_adv;
    logic                 x_adv;
    logic                 x_take;
    logic                 rf_we;
    logic [WORD_W-1:0]    a;
    logic [WORD_W-1:0]    b;
    logic [WORD_W-1:0]    pc_inc;
    logic                 take_jump;
    logic [WORD_W-1:0]    n_pc;
    logic [WORD_W-1:0]    n_sp;
    logic                 n_zf;
    logic                 n_lf;
    t_res                 n_res;
    logic                 stk_we;
    logic                 stk_re;
    logic [STK_IDX_W-1:0] stk_waddr;
    logic [STK_IDX_W-1:0] stk_raddr;

    // A popped word arrives from the stack memory while the beat sits in the result stage.
    assign w_val = r_w.pop ? (r_stk_rd_vld ? r_stk_rd : STACK_FILL) : r_w.value;
    assign w_fwd = r_w_vld && r_w.wr;

    assign w_adv      = r_w_vld && i_pop;
    assign x_adv      = r_x_vld && (!r_w_vld || i_pop);
    assign x_take     = i_dec_valid && (!r_x_vld || x_adv);
    assign o_dec_take = x_take;
    assign rf_we      = w_adv && r_w.wr;

    always_comb begin
        o_res       = r_w;
        o_res.value = w_val;
        o_res_valid = r_w_vld;
    end

    // Register file: operands are captured as a beat enters execute, with the
    // write of the same edge passed through.
    always_ff @(posedge i_clk) begin
        if (rf_we) begin
            r_rf[r_w.idx] <= w_val;
        end
        if (x_take) begin
            r_x <= i_dec;
            if (rf_we && r_w.idx == i_dec.rm) begin
                r_ra <= w_val;
            end else begin
                r_ra <= r_rf_vld[i_dec.rm] ? r_rf[i_dec.rm] : '0;
            end
            if (rf_we && r_w.idx == i_dec.rn) begin
                r_rb <= w_val;
            end else begin
                r_rb <= r_rf_vld[i_dec.rn] ? r_rf[i_dec.rn] : '0;
            end
        end
    end

    always_comb begin
        a = (w_fwd && r_w.idx == r_x.rm) ? w_val : r_ra;
        b = (w_fwd && r_w.idx == r_x.rn) ? w_val : r_rb;

        pc_inc    = r_pc + PC_STEP;
        take_jump = 1'b0;
        n_sp      = r_sp;
        n_zf      = r_zf;
        n_lf      = r_lf;
        stk_we    = 1'b0;
        stk_re    = 1'b0;
        n_res     = '0;

        unique case (r_x.op)
            OP_NOP: ;
            OP_MOV_R: begin
                n_res.wr    = 1'b1;
                n_res.value = a;
            end
            OP_MOV_I: begin
                n_res.wr    = 1'b1;
                n_res.value = {{(WORD_W - 8){1'b0}}, r_x.imm};
            end
            OP_PUSH: begin
                stk_we = 1'b1;
                n_sp   = r_sp - SP_STEP;
            end
            OP_POP: begin
                stk_re    = 1'b1;
                n_sp      = r_sp + SP_STEP;
                n_res.wr  = 1'b1;
                n_res.pop = 1'b1;
            end
            OP_CMP: begin
                n_zf = (a == b);
                n_lf = (a < b);
            end
            OP_JMP: take_jump = 1'b1;
            OP_JEQ: take_jump = r_zf && !r_lf;
            OP_JLT: take_jump = !r_zf && r_lf;
            OP_JGT: take_jump = !r_zf && !r_lf;
            OP_ADD: begin
                n_res.wr    = 1'b1;
                n_res.value = a + b;
            end
            OP_SUB: begin
                n_res.wr    = 1'b1;
                n_res.value = a - b;
            end
            OP_MUL: begin
                n_res.wr    = 1'b1;
                n_res.value = a * b;
            end
            OP_AND: begin
                n_res.wr    = 1'b1;
                n_res.value = a & b;
            end
            OP_OR: begin
                n_res.wr    = 1'b1;
                n_res.value = a | b;
            end
            OP_XOR: begin
                n_res.wr    = 1'b1;
                n_res.value = a ^ b;
            end
        endcase

        n_pc          = take_jump ? pc_inc + r_x.off : pc_inc;
        n_res.idx     = n_res.wr ? r_x.rd : '0;
        n_res.next_pc = n_pc;
        n_res.zf      = n_zf;
        n_res.lf      = n_lf;
        n_res.sp      = n_sp;
        n_res.halt    = r_x.halt;

        // The stack wraps: the slot is the word address modulo the depth.
        stk_waddr = r_sp[STK_IDX_W:1];
        stk_raddr = n_sp[STK_IDX_W:1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_vld   <= 1'b0;
            r_w_vld   <= 1'b0;
            r_pc      <= '0;
            r_sp      <= RESET_SP;
            r_zf      <= 1'b0;
            r_lf      <= 1'b0;
            r_rf_vld  <= '0;
            r_stk_vld <= '0;
        end else begin
            if (x_take) begin
                r_x_vld <= 1'b1;
            end else if (x_adv) begin
                r_x_vld <= 1'b0;
            end
            if (x_adv) begin
                r_w_vld <= 1'b1;
                r_pc    <= n_pc;
                r_sp    <= n_sp;
                r_zf    <= n_zf;
                r_lf    <= n_lf;
            end else if (w_adv) begin
                r_w_vld <= 1'b0;
            end
            if (rf_we) begin
                r_rf_vld[r_w.idx] <= 1'b1;
            end
            if (x_adv && stk_we) begin
                r_stk_vld[stk_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (x_adv) begin
            r_w <= n_res;
        end
        if (x_adv && stk_we) begin
            r_stk[stk_waddr] <= b;
        end
        if (x_adv && stk_re) begin
            r_stk_rd     <= r_stk[stk_raddr];
            r_stk_rd_vld <= r_stk_vld[stk_raddr];
        end
    end

endmodule

// ===== hw/rtl/tiny_cpu_execute_step_top.sv =====
// Channel  | Handshake             | Beat fields
// ---------+-----------------------+-------------------------------------------------
// input    | push / full           | i_instr
// result   | empty / pop           | o_next_pc, o_reg_write, o_reg_index, o_reg_value,
//          |                       | o_flag_zero, o_flag_less, o_stack_ptr, o_halted
//
// One instruction per cycle is sustained while results are popped; a result passes
// through the decode queue, the execute register and the result register.
// Register file and stack memory results are forwarded, so back-to-back dependent
// instructions do not stall.
// Reset is synchronous; it clears the state and the stack valid bits at once, with no sweep.
// A stalled result holds in the result register while the two-entry decode queue keeps
// taking beats until it is full.
module tiny_cpu_execute_step_top import tce_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic [WORD_W-1:0]   i_instr,
    output logic                empty,
    input  logic                pop,
    output logic [WORD_W-1:0]   o_next_pc,
    output logic                o_reg_write,
    output logic [GP_IDX_W-1:0] o_reg_index,
    output logic [WORD_W-1:0]   o_reg_value,
    output logic                o_flag_zero,
    output logic                o_flag_less,
    output logic [WORD_W-1:0]   o_stack_ptr,
    output logic                o_halted
);

    t_dec dec;
    logic dec_valid;
    logic dec_take;
    t_res res;
    logic res_valid;

    tce_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_instr     (i_instr),
        .o_full      (full),
        .o_dec       (dec),
        .o_dec_valid (dec_valid),
        .i_dec_take  (dec_take)
    );

    tce_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dec       (dec),
        .i_dec_valid (dec_valid),
        .o_dec_take  (dec_take),
        .o_res       (res),
        .o_res_valid (res_valid),
        .i_pop       (pop)
    );

    assign empty       = !res_valid;
    assign o_next_pc   = res.next_pc;
    assign o_reg_write = res.wr;
    assign o_reg_index = res.idx;
    assign o_reg_value = res.value;
    assign o_flag_zero = res.zf;
    assign o_flag_less = res.lf;
    assign o_stack_ptr = res.sp;
    assign o_halted    = res.halt;

endmodule

// ===== hw/rtl/tce_checker.sv =====
module tce_checker import tce_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                empty,
    input logic                pop,
    input logic [WORD_W-1:0]   o_next_pc,
    input logic                o_reg_write,
    input logic [GP_IDX_W-1:0] o_reg_index,
    input logic [WORD_W-1:0]   o_reg_value,
    input logic [WORD_W-1:0]   o_stack_ptr,
    input logic                o_halted
);

    // Nothing is left to deliver after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    // A beat without a register write carries a zero index and value.
    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_reg_write) |-> (o_reg_index == '0 && o_reg_value == '0))
        else $error("register fields set on a beat without a write");

    // The halt word writes no register.
    a_halt_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_halted) |-> !o_reg_write)
        else $error("halt beat wrote a register");

    // The stack pointer moves in steps of two from an even reset value.
    a_sp_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_stack_ptr[0] == 1'b0))
        else $error("stack pointer odd");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_next_pc) && $stable(o_reg_value)
                              && $stable(o_stack_ptr)))
        else $error("stalled result beat changed");

endmodule

bind tiny_cpu_execute_step_top tce_checker u_tce_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb
    import tce_pkg::*;
();

    localparam int unsigned RANDOM_ITEMS    = 560;
    localparam int unsigned DEEP_PUSHES     = 300;
    localparam int unsigned FULL_RATE_ITEMS = 40;
    localparam int unsigned CYCLE_LIMIT     = 400_000;
    localparam int unsigned TAIL_CYCLES     = 10;

    // Opcodes that decode to nothing but a program counter step.
    localparam logic [3:0] SPARE_OPC [8] = '{4'd2, 4'd3, 4'd10, 4'd11,
                                             4'd12, 4'd13, 4'd14, 4'd15};

    typedef struct packed {
        logic [WORD_W-1:0]   next_pc;
        logic                wr;
        logic [GP_IDX_W-1:0] idx;
        logic [WORD_W-1:0]   value;
        logic                zf;
        logic                lf;
        logic [WORD_W-1:0]   sp;
        logic                halt;
    } step_beat_t;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              typed;
        step_beat_t        want;
    } dir_row_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                push = 1'b0;
    logic                pop = 1'b0;
    logic [WORD_W-1:0]   i_instr = '0;
    logic                full;
    logic                empty;
    logic [WORD_W-1:0]   o_next_pc;
    logic                o_reg_write;
    logic [GP_IDX_W-1:0] o_reg_index;
    logic [WORD_W-1:0]   o_reg_value;
    logic                o_flag_zero;
    logic                o_flag_less;
    logic [WORD_W-1:0]   o_stack_ptr;
    logic                o_halted;

    tiny_cpu_execute_step_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_instr     (i_instr),
        .empty       (empty),
        .pop         (pop),
        .o_next_pc   (o_next_pc),
        .o_reg_write (o_reg_write),
        .o_reg_index (o_reg_index),
        .o_reg_value (o_reg_value),
        .o_flag_zero (o_flag_zero),
        .o_flag_less (o_flag_less),
        .o_stack_ptr (o_stack_ptr),
        .o_halted    (o_halted)
    );

    always #4 i_clk = ~i_clk;

    // Architectural state of the predicted machine.
    logic [WORD_W-1:0] arch_regs [NUM_GP];
    logic [WORD_W-1:0] stack_words [STACK_DEPTH];
    logic [WORD_W-1:0] arch_pc;
    logic [WORD_W-1:0] arch_sp;
    logic              arch_zf;
    logic              arch_lf;

    step_beat_t pending_steps [$];
    step_beat_t seen_beat;
    logic       in_fire = 1'b0;
    logic       out_fire = 1'b0;
    logic       gaps_on = 1'b1;
    logic       stall_on = 1'b1;
    int unsigned n_items, n_results, n_mismatch, n_push, n_pop, n_taken, n_cycles;

    // Directed rows: the first six are typed in, starting from the reset state.
    dir_row_t dir_tbl [25] = '{
        '{16'h0000, 1'b1, '{16'h0002, 1'b0, 3'd0, 16'h0000, 1'b1, 1'b0, 16'h8200, 1'b0}},
        '{16'h19FF, 1'b1, '{16'h0004, 1'b1, 3'd1, 16'h00FF, 1'b1, 1'b0, 16'h8200, 1'b0}},
        '{16'h1F00, 1'b1, '{16'h0006, 1'b1, 3'd7, 16'h0000, 1'b1, 1'b0, 16'h8200, 1'b0}},
        '{16'h0202, 1'b1, '{16'h0008, 1'b1, 3'd2, 16'hAAAA, 1'b1, 1'b0, 16'h8202, 1'b0}},
        '{16'h0005, 1'b1, '{16'h000A, 1'b0, 3'd0, 16'h0000, 1'b1, 1'b0, 16'h8200, 1'b0}},
        '{16'hFFFF, 1'b1, '{16'h000C, 1'b0, 3'd0, 16'h0000, 1'b1, 1'b0, 16'h8200, 1'b1}},
        '{16'h0202, 1'b0, '0},  // pops back the word pushed above
        '{16'h1320, 1'b0, '0},
        '{16'h4424, 1'b0, '0},
        '{16'h55E4, 1'b0, '0},  // subtract wraps below zero
        '{16'h66B4, 1'b0, '0},
        '{16'h70B8, 1'b0, '0},
        '{16'h89B0, 1'b0, '0},  // type bit set on an ALU op
        '{16'h92D4, 1'b0, '0},
        '{16'h00E4, 1'b0, '0},
        '{16'h0805, 1'b0, '0},
        '{16'h0807, 1'b0, '0},
        '{16'h0806, 1'b0, '0},
        '{16'h003F, 1'b0, '0},
        '{16'h0BFF, 1'b0, '0},  // largest forward offset
        '{16'h0C00, 1'b0, '0},  // largest backward offset
        '{16'h006F, 1'b0, '0},
        '{16'h0FFD, 1'b0, '0},
        '{16'h2ABC, 1'b0, '0},
        '{16'hFFFE, 1'b0, '0}
    };

    function automatic void reset_machine();
        foreach (arch_regs[i]) arch_regs[i] = '0;
        foreach (stack_words[i]) stack_words[i] = STACK_FILL;
        arch_pc = '0;
        arch_sp = RESET_SP;
        arch_zf = 1'b0;
        arch_lf = 1'b0;
    endfunction

    function automatic step_beat_t execute_word(logic [WORD_W-1:0] w);
        logic [3:0]          opc;
        logic                ty;
        logic [GP_IDX_W-1:0] rd, rm, rn;
        logic [1:0]          sub;
        logic [WORD_W-1:0]   a, b, res;
        logic                wr, take;
        opc  = w[15:12];
        ty   = w[11];
        rd   = w[10:8];
        rm   = w[7:5];
        rn   = w[4:2];
        sub  = w[1:0];
        res  = '0;
        wr   = 1'b0;
        take = 1'b0;
        arch_pc = arch_pc + PC_STEP;
        a = arch_regs[rm];
        b = arch_regs[rn];
        if (opc == OPC_MOV) begin
            res = ty ? {8'h00, w[7:0]} : a;
            wr  = 1'b1;
        end else if (opc == OPC_SYS && !ty) begin
            case (sub)
                SSUB_PUSH: begin
                    stack_words[arch_sp[STK_IDX_W:1]] = b;
                    arch_sp = arch_sp - SP_STEP;
                    n_push++;
                end
                SSUB_POP: begin
                    arch_sp = arch_sp + SP_STEP;
                    res = stack_words[arch_sp[STK_IDX_W:1]];
                    wr  = 1'b1;
                    n_pop++;
                end
                default: begin
                    arch_zf = (a == b);
                    arch_lf = (a < b);
                end
            endcase
        end else if (opc == OPC_SYS) begin
            case (sub)
                JSUB_ALWAYS: take = 1'b1;
                JSUB_EQ:     take = arch_zf && !arch_lf;
                JSUB_LT:     take = !arch_zf && arch_lf;
                default:     take = !arch_zf && !arch_lf;
            endcase
        end else begin
            wr = 1'b1;
            case (opc)
                OPC_ADD: res = a + b;
                OPC_SUB: res = a - b;
                OPC_MUL: res = a * b;
                OPC_AND: res = a & b;
                OPC_OR:  res = a | b;
                OPC_XOR: res = a ^ b;
                default: wr = 1'b0;
            endcase
        end
        if (take) begin
            arch_pc = arch_pc + {{7{w[10]}}, w[10:2]};
            n_taken++;
        end
        if (wr) arch_regs[rd] = res;
        return '{arch_pc, wr, wr ? rd : '0, wr ? res : '0, arch_zf, arch_lf, arch_sp,
                 w == HALT_WORD};
    endfunction

    // All signals settle between the rising edges, so the falling edge sees the
    // values that the next rising edge will act on.
    always @(negedge i_clk) begin
        in_fire   = i_rst_n && push && !full;
        out_fire  = i_rst_n && pop && !empty;
        seen_beat = '{o_next_pc, o_reg_write, o_reg_index, o_reg_value,
                      o_flag_zero, o_flag_less, o_stack_ptr, o_halted};
    end

    always @(posedge i_clk) begin
        pop <= i_rst_n && (!stall_on || $urandom_range(99) >= 25);
    end

    always @(posedge i_clk) begin
        step_beat_t want;
        if (out_fire) begin
            n_results++;
            if (pending_steps.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("Result beat %0d arrived with nothing outstanding", n_results);
            end else begin
                want = pending_steps.pop_front();
                if (seen_beat !== want) begin
                    n_mismatch++;
                    if (n_mismatch <= 10) begin
                        $display("Result beat %0d mismatch:", n_results);
                        $display("  expected pc=%h wr=%b idx=%0d val=%h z=%b l=%b sp=%h halt=%b",
                                 want.next_pc, want.wr, want.idx, want.value,
                                 want.zf, want.lf, want.sp, want.halt);
                        $display("  actual   pc=%h wr=%b idx=%0d val=%h z=%b l=%b sp=%h halt=%b",
                                 seen_beat.next_pc, seen_beat.wr, seen_beat.idx,
                                 seen_beat.value, seen_beat.zf, seen_beat.lf,
                                 seen_beat.sp, seen_beat.halt);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     n_cycles, pending_steps.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_word(input logic [WORD_W-1:0] w, input logic typed = 1'b0,
                             input step_beat_t want = '0);
        step_beat_t pred;
        while (gaps_on && $urandom_range(99) < 25) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push    <= 1'b1;
        i_instr <= w;
        do @(posedge i_clk); while (!in_fire);
        pred = execute_word(w);
        pending_steps.push_back(typed ? want : pred);
        n_items++;
    endtask

    task automatic drain_results();
        push <= 1'b0;
        while (pending_steps.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        int unsigned        k, rand_end;
        logic [3:0]         opc;
        logic [GP_IDX_W-1:0] r;
        reset_machine();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tbl[i])
            send_word(dir_tbl[i].word, dir_tbl[i].typed, dir_tbl[i].want);
        // Let the pipeline run dry once before the random traffic starts.
        drain_results();

        rand_end = n_items + RANDOM_ITEMS;
        while (n_items < rand_end) begin
            case ($urandom_range(9))
                0, 1: send_word(16'($urandom));
                2: send_word({OPC_MOV, 1'b1, 3'($urandom), 8'($urandom)});
                3: send_word({OPC_MOV, 1'b0, 11'($urandom)});
                4, 5: begin
                    opc = 4'(OPC_ADD + $urandom_range(5));
                    send_word({opc, 12'($urandom)});
                end
                6: begin
                    // Compare, then a branch that reads the fresh flags.
                    r = 3'($urandom);
                    send_word({OPC_SYS, 1'b0, 3'($urandom), r,
                               $urandom_range(3) == 0 ? r : 3'($urandom),
                               $urandom_range(1) ? SSUB_CMP : SSUB_CMP_ALT});
                    send_word({OPC_SYS, 1'b1, 9'($urandom), 2'($urandom)});
                end
                7: begin
                    k = $urandom_range(1, 8);
                    repeat (k) send_word({OPC_SYS, 1'b0, 9'($urandom), SSUB_PUSH});
                    repeat (k) send_word({OPC_SYS, 1'b0, 9'($urandom), SSUB_POP});
                end
                8: begin
                    if ($urandom_range(3) == 0)
                        send_word(HALT_WORD);
                    else
                        send_word({SPARE_OPC[$urandom_range(7)], 12'($urandom)});
                end
                default: send_word({OPC_SYS, 1'b1, 11'($urandom)});
            endcase
        end

        // Push deeper than the stack store so that it wraps, then unwind it.
        for (k = 0; k < DEEP_PUSHES; k++) begin
            if (k % 5 == 0)
                send_word({OPC_MOV, 1'b1, 3'($urandom), 8'($urandom)});
            send_word({OPC_SYS, 1'b0, 9'($urandom), SSUB_PUSH});
        end
        repeat (DEEP_PUSHES) send_word({OPC_SYS, 1'b0, 9'($urandom), SSUB_POP});
        drain_results();

        // Pop and push at full rate with no idling on either side.
        gaps_on  = 1'b0;
        stall_on = 1'b0;
        repeat (FULL_RATE_ITEMS) send_word({OPC_SYS, 1'b0, 9'($urandom), SSUB_POP});
        repeat (FULL_RATE_ITEMS) send_word({OPC_SYS, 1'b0, 9'($urandom), SSUB_PUSH});
        gaps_on  = 1'b1;
        stall_on = 1'b1;
        repeat (40) send_word(16'($urandom));

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Executed %0d instructions and checked %0d results in %0d cycles.",
                 n_items, n_results, n_cycles);
        $display("Covered %0d pushes, %0d pops, %0d taken branches and a full stack wrap.",
                 n_push, n_pop, n_taken);
        if (n_mismatch == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatching results", n_mismatch);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
